// ----- sv/lps_pkg.sv -----
// ----------------------------------------------------------------------------
// lps_pkg
// Shared types and constants for the latency percentile collector.
// ----------------------------------------------------------------------------
package lps_pkg;

    // Field widths fixed by the stream format
    localparam int LAT_FIELD_W = 24;
    localparam int DEC_W       = 2;
    localparam int CNT_FIELD_W = 9;
    localparam int PCT_W       = 7;

    // Input tdata layout
    localparam int IN_LAT_LSB = 0;
    localparam int IN_DEC_LSB = LAT_FIELD_W;
    localparam int IN_DATA_W  = 32;

    // Output tdata layout
    localparam int OUT_RC_LSB   = 0;
    localparam int OUT_AC_LSB   = OUT_RC_LSB + CNT_FIELD_W;
    localparam int OUT_RV_LSB   = OUT_AC_LSB + CNT_FIELD_W;
    localparam int OUT_RJ_LSB   = OUT_RV_LSB + CNT_FIELD_W;
    localparam int OUT_LOW_LSB  = OUT_RJ_LSB + CNT_FIELD_W;
    localparam int OUT_HIGH_LSB = OUT_LOW_LSB + LAT_FIELD_W;
    localparam int OUT_MAX_LSB  = OUT_HIGH_LSB + LAT_FIELD_W;
    localparam int OUT_OVF_BIT  = OUT_MAX_LSB + LAT_FIELD_W;
    localparam int OUT_DATA_W   = 112;

    // Operation codes (tuser)
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // Decision classes
    localparam logic [DEC_W-1:0] DEC_ACCEPT = 2'd0;
    localparam logic [DEC_W-1:0] DEC_REVIEW = 2'd1;
    localparam logic [DEC_W-1:0] DEC_REJECT = 2'd2;

    // Configuration register indexes
    localparam logic REG_LOW_PCT  = 1'b0;
    localparam logic REG_HIGH_PCT = 1'b1;

    localparam logic [PCT_W-1:0] LOW_PCT_RESET  = 7'd50;
    localparam logic [PCT_W-1:0] HIGH_PCT_RESET = 7'd95;

    // Weight of one rank position in percent units
    localparam int RANK_STEP = 100;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic drain;
    } cell_ctrl_t;

endpackage

// ----- sv/latency_percentile_stats_top.sv -----
// ----------------------------------------------------------------------------
// latency_percentile_stats_top
// Frame latency collector with nearest-rank percentile reports.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Content
//  s_*      in   s_tvalid/s_tready  tuser: operation; tdata: latency_us, decision
//  m_*      out  m_tvalid/m_tready  tdata: counts, two percentiles, max, overflowed
//  cfg_*    in   cfg_wen            cfg_index selects low/high percentile register
//
//  Records stream back to back while no report is in progress, each one
//  inserted into the sorted cell chain by one parallel compare-and-shift.
//  A report request drains the chain through cell 0, one entry per cycle;
//  the input stays busy until the result is loaded into the output register.
//  Reset clears counts, flags and the output valid; cell contents need none.
//  A waiting result does not block records; a second report waits for it.
// ----------------------------------------------------------------------------
module latency_percentile_stats_top
    import lps_pkg::*;
#(
    parameter int MAX_RECORDS  = 256,
    parameter int LATENCY_BITS = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave request stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // [23:0] latency_us, [25:24] decision
    input  logic                   s_tuser,   // [0] operation
    // master result stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [8:0] record_count, [17:9] accept_count, [26:18] review_count,
    // [35:27] reject_count, [59:36] low_pct_latency, [83:60] high_pct_latency,
    // [107:84] max_latency, [108] overflowed
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // configuration write port
    input  logic                   cfg_wen,
    input  logic                   cfg_index,
    input  logic [PCT_W-1:0]       cfg_data
);

    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int PW = PCT_W + CW;

    // ---------------------------------------------------------------- config
    logic [PCT_W-1:0] low_pct_reg;
    logic [PCT_W-1:0] high_pct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_pct_reg  <= LOW_PCT_RESET;
            high_pct_reg <= HIGH_PCT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                REG_LOW_PCT:  low_pct_reg  <= cfg_data;
                REG_HIGH_PCT: high_pct_reg <= cfg_data;
                default:      ;
            endcase
        end
    end

    // --------------------------------------------------------- input decode
    logic                    in_op;
    logic [LAT_FIELD_W-1:0]  in_lat;
    logic [DEC_W-1:0]        in_dec;
    logic [LATENCY_BITS-1:0] lat_ext;
    logic                    in_fire;
    logic                    rec_fire;
    logic                    rpt_fire;

    assign in_op    = s_tuser;
    assign in_lat   = s_tdata[IN_LAT_LSB +: LAT_FIELD_W];
    assign in_dec   = s_tdata[IN_DEC_LSB +: DEC_W];
    assign lat_ext  = LATENCY_BITS'(32'(in_lat));
    assign in_fire  = s_tvalid && s_tready;
    assign rec_fire = in_fire && (in_op == OP_RECORD);
    assign rpt_fire = in_fire && (in_op == OP_REPORT);

    // ------------------------------------------------------ counts and flag
    logic [CW-1:0] count_reg;
    logic [CW-1:0] accept_reg;
    logic [CW-1:0] review_reg;
    logic [CW-1:0] reject_reg;
    logic          drop_reg;
    logic          full;

    assign full = (count_reg == CW'(MAX_RECORDS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            accept_reg <= '0;
            review_reg <= '0;
            reject_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (rpt_fire)
        begin
            // report snapshots below, then start a fresh run
            count_reg  <= '0;
            accept_reg <= '0;
            review_reg <= '0;
            reject_reg <= '0;
            drop_reg   <= 1'b0;
        end
        else if (rec_fire)
        begin
            if (full)
            begin
                // drop the record entirely, remember it for the report
                drop_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CW'(1);
                case (in_dec)
                    DEC_ACCEPT: accept_reg <= accept_reg + CW'(1);
                    DEC_REVIEW: review_reg <= review_reg + CW'(1);
                    DEC_REJECT: reject_reg <= reject_reg + CW'(1);
                    default:    ; // stored, but in no class
                endcase
            end
        end
    end

    // ------------------------------------------------------------ cell chain
    cell_ctrl_t              ctrl;
    logic [LATENCY_BITS-1:0] head;
    state_t                  state_reg;
    state_t                  state_next;

    assign ctrl.insert = rec_fire && !full;
    assign ctrl.drain  = (state_reg == ST_DRAIN);

    lps_chain #(
        .MAX_RECORDS  (MAX_RECORDS),
        .LATENCY_BITS (LATENCY_BITS),
        .CW           (CW)
    ) u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .new_lat (lat_ext),
        .count   (count_reg),
        .head    (head)
    );

    // ------------------------------------------------------- report drain
    // Entry k (0-based) is the nearest-rank pick while 100*k < p*n; the last
    // such k wins, entry 0 is always taken and the run end clamps to n.
    logic [CW-1:0]           rpt_n_reg;
    logic [CW-1:0]           rpt_acc_reg;
    logic [CW-1:0]           rpt_rev_reg;
    logic [CW-1:0]           rpt_rej_reg;
    logic                    rpt_drop_reg;
    logic [CW-1:0]           k_reg;
    logic [PW-1:0]           acc_reg;
    logic [PW-1:0]           pn_low_reg;
    logic [PW-1:0]           pn_high_reg;
    logic [LATENCY_BITS-1:0] low_cap_reg;
    logic [LATENCY_BITS-1:0] high_cap_reg;
    logic [LATENCY_BITS-1:0] max_cap_reg;
    logic                    last_entry;

    assign last_entry = (k_reg == rpt_n_reg - CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_n_reg <= '0;
            k_reg     <= '0;
            acc_reg   <= '0;
        end
        else if (rpt_fire)
        begin
            rpt_n_reg <= count_reg;
            k_reg     <= '0;
            acc_reg   <= '0;
        end
        else if (state_reg == ST_DRAIN)
        begin
            k_reg   <= k_reg + CW'(1);
            acc_reg <= acc_reg + PW'(RANK_STEP);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rpt_fire)
        begin
            rpt_acc_reg  <= accept_reg;
            rpt_rev_reg  <= review_reg;
            rpt_rej_reg  <= reject_reg;
            rpt_drop_reg <= drop_reg;
            pn_low_reg   <= PW'(low_pct_reg) * PW'(count_reg);
            pn_high_reg  <= PW'(high_pct_reg) * PW'(count_reg);
            // an empty report keeps these at zero
            low_cap_reg  <= '0;
            high_cap_reg <= '0;
            max_cap_reg  <= '0;
        end
        else if (state_reg == ST_DRAIN)
        begin
            if ((k_reg == '0) || (acc_reg < pn_low_reg))
            begin
                low_cap_reg <= head;
            end
            if ((k_reg == '0) || (acc_reg < pn_high_reg))
            begin
                high_cap_reg <= head;
            end
            if (last_entry)
            begin
                max_cap_reg <= head;
            end
        end
    end

    // --------------------------------------------------------- control FSM
    logic load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (rpt_fire)
                begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (last_entry)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the output register is free
                load = !m_tvalid || m_tready;
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------ output register
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] out_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // pack the result fields; spare top bits stay zero
    always_comb
    begin
        out_word = '0;
        out_word[OUT_RC_LSB +: CNT_FIELD_W]   = CNT_FIELD_W'(32'(rpt_n_reg));
        out_word[OUT_AC_LSB +: CNT_FIELD_W]   = CNT_FIELD_W'(32'(rpt_acc_reg));
        out_word[OUT_RV_LSB +: CNT_FIELD_W]   = CNT_FIELD_W'(32'(rpt_rev_reg));
        out_word[OUT_RJ_LSB +: CNT_FIELD_W]   = CNT_FIELD_W'(32'(rpt_rej_reg));
        out_word[OUT_LOW_LSB +: LAT_FIELD_W]  = LAT_FIELD_W'(32'(low_cap_reg));
        out_word[OUT_HIGH_LSB +: LAT_FIELD_W] = LAT_FIELD_W'(32'(high_cap_reg));
        out_word[OUT_MAX_LSB +: LAT_FIELD_W]  = LAT_FIELD_W'(32'(max_cap_reg));
        out_word[OUT_OVF_BIT]                 = rpt_drop_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= out_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------ assertions
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_RECORDS))
        else $error("fill count beyond capacity");

    a_class_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(accept_reg) + 32'(review_reg) + 32'(reject_reg)) <= 32'(count_reg))
        else $error("class counts exceed record count");

    a_drain_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (k_reg < rpt_n_reg))
        else $error("drain ran past stored records");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside report completion");

endmodule

// ----- sv/lps_cell.sv -----
// ----------------------------------------------------------------------------
// lps_cell
// One slot of the sorted latency chain.
// ----------------------------------------------------------------------------
module lps_cell
    import lps_pkg::*;
#(
    parameter int LATENCY_BITS = 24
)
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [LATENCY_BITS-1:0] new_lat,
    input  logic                    occupied,
    input  logic                    prev_gt,
    input  logic [LATENCY_BITS-1:0] prev_val,
    input  logic [LATENCY_BITS-1:0] next_val,
    output logic                    gt,
    output logic [LATENCY_BITS-1:0] val
);

    logic [LATENCY_BITS-1:0] val_reg;
    logic [LATENCY_BITS-1:0] val_next;

    // An empty slot counts as larger than any latency
    assign gt  = !occupied || (val_reg > new_lat);
    assign val = val_reg;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.drain)
        begin
            val_next = next_val;
        end
        else if (ctrl.insert && gt)
        begin
            // shift right when the left neighbor also moves, else take the new one
            val_next = prev_gt ? prev_val : new_lat;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

endmodule

// ----- sv/lps_chain.sv -----
// ----------------------------------------------------------------------------
// lps_chain
// Row of cells holding the latencies in ascending order.
// ----------------------------------------------------------------------------
module lps_chain
    import lps_pkg::*;
#(
    parameter int MAX_RECORDS  = 256,
    parameter int LATENCY_BITS = 24,
    parameter int CW           = 9
)
(
    input  logic                    clk,
    input  cell_ctrl_t              ctrl,
    input  logic [LATENCY_BITS-1:0] new_lat,
    input  logic [CW-1:0]           count,
    output logic [LATENCY_BITS-1:0] head
);

    logic [LATENCY_BITS-1:0] val [MAX_RECORDS];
    logic                    gt  [MAX_RECORDS];

    for (genvar i = 0; i < MAX_RECORDS; i++)
    begin : g_cell
        logic                    occ;
        logic                    left_gt;
        logic [LATENCY_BITS-1:0] left_val;
        logic [LATENCY_BITS-1:0] right_val;

        assign occ = (CW'(i) < count);

        if (i == 0)
        begin : g_first
            assign left_gt  = 1'b0;
            assign left_val = new_lat;
        end
        else
        begin : g_mid
            assign left_gt  = gt[i-1];
            assign left_val = val[i-1];
        end

        if (i == MAX_RECORDS - 1)
        begin : g_last
            assign right_val = new_lat;
        end
        else
        begin : g_inner
            assign right_val = val[i+1];
        end

        lps_cell #(
            .LATENCY_BITS (LATENCY_BITS)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .new_lat  (new_lat),
            .occupied (occ),
            .prev_gt  (left_gt),
            .prev_val (left_val),
            .next_val (right_val),
            .gt       (gt[i]),
            .val      (val[i])
        );
    end

    assign head = val[0];

endmodule

// ----- test/latency_percentile_stats_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// latency_percentile_stats_top_tb
// Self-checking bench for the nearest-rank latency percentile collector.
// ----------------------------------------------------------------------------
// Drives record and report requests into the slave stream, first from a
// short table of directed rows (empty reports, latency extremes, an unused
// decision code, equal latencies, a full store with dropped records), then
// from random frames: a run of records closed by a report. Each frame phase
// runs under its own pair of percentile settings, zero and 127 among them.
// A sorted-store model in the bench computes every report; results are
// compared field by field as they leave the master stream. The sender works
// in bursts, the receiver stalls on its own pattern and holds off once for a
// long stretch so that a second report backs up into the input.
// ----------------------------------------------------------------------------
module latency_percentile_stats_top_tb;
    import lps_pkg::*;

    localparam int MAX_REC         = 256;
    localparam int SETTLE_CYCLES   = MAX_REC + 8;    // longest drain plus margin
    localparam int HOLD_OFF_CYCLES = 1500;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int PHASE_ITEMS     = 250;
    localparam int PHASE_REPORTS   = 8;

    // Decision code with no class of its own
    localparam logic [DEC_W-1:0] DEC_UNUSED = 2'd3;

    typedef struct packed {
        logic [CNT_FIELD_W-1:0] rec_n;
        logic [CNT_FIELD_W-1:0] acc_n;
        logic [CNT_FIELD_W-1:0] rev_n;
        logic [CNT_FIELD_W-1:0] rej_n;
        logic [LAT_FIELD_W-1:0] low_lat;
        logic [LAT_FIELD_W-1:0] high_lat;
        logic [LAT_FIELD_W-1:0] max_lat;
        logic                   ovf;
    } report_t;

    // One row of the directed table; fixed rows carry their own answer
    typedef struct packed {
        logic                   op;
        logic [LAT_FIELD_W-1:0] lat;
        logic [DEC_W-1:0]       dec;
        logic [15:0]            reps;
        logic                   fixed;
        report_t                want;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = OP_RECORD;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_wen   = 1'b0;
    logic                  cfg_index = REG_LOW_PCT;
    logic [PCT_W-1:0]      cfg_data  = '0;

    // Model of the collector: sorted latencies, class totals, drop flag
    logic [LAT_FIELD_W-1:0] lat_sorted [0:MAX_REC-1];
    int unsigned            held_n;
    int unsigned            acc_tot;
    int unsigned            rev_tot;
    int unsigned            rej_tot;
    bit                     dropped;
    logic [PCT_W-1:0]       low_pct  = LOW_PCT_RESET;
    logic [PCT_W-1:0]       high_pct = HIGH_PCT_RESET;

    report_t   awaited_reports [$];
    stim_row_t directed_rows [$];

    int mismatches   = 0;
    int results_seen = 0;
    int sent_items   = 0;
    int sent_reports = 0;
    int burst_left   = 0;
    int cycle_count  = 0;

    latency_percentile_stats_top #(
        .MAX_RECORDS  (MAX_REC),
        .LATENCY_BITS (LAT_FIELD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Assert reset once and release it off the rising edge
    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("latency_percentile_stats_top_tb: done, errors");
            $finish;
        end
    end

    function automatic report_t mk_report(input int n, input int a, input int r, input int j,
                                          input int lo, input int hi, input int mx,
                                          input int ovf);
        report_t rep;
        rep.rec_n    = CNT_FIELD_W'(n);
        rep.acc_n    = CNT_FIELD_W'(a);
        rep.rev_n    = CNT_FIELD_W'(r);
        rep.rej_n    = CNT_FIELD_W'(j);
        rep.low_lat  = LAT_FIELD_W'(lo);
        rep.high_lat = LAT_FIELD_W'(hi);
        rep.max_lat  = LAT_FIELD_W'(mx);
        rep.ovf      = ovf[0];
        return rep;
    endfunction

    // Nearest rank: ceil(p*n/100), at least 1, at most n
    function automatic logic [LAT_FIELD_W-1:0] rank_latency(input logic [PCT_W-1:0] pct);
        int unsigned rank;
        rank = (int'(pct) * held_n + RANK_STEP - 1) / RANK_STEP;
        if (rank < 1)
            rank = 1;
        if (rank > held_n)
            rank = held_n;
        return lat_sorted[rank-1];
    endfunction

    // Advance the model by one accepted request; a report yields a result
    task automatic collect_request(input logic op, input logic [LAT_FIELD_W-1:0] lat,
                                   input logic [DEC_W-1:0] dec,
                                   output bit has_rep, output report_t rep);
        int unsigned pos;
        has_rep = 1'b0;
        rep     = '0;
        if (op == OP_RECORD)
        begin
            if (held_n >= MAX_REC)
            begin
                dropped = 1'b1;
                return;
            end
            // shift larger entries up; equal ones stay ahead of the new record
            pos = held_n;
            while (pos > 0 && lat_sorted[pos-1] > lat)
            begin
                lat_sorted[pos] = lat_sorted[pos-1];
                pos--;
            end
            lat_sorted[pos] = lat;
            held_n++;
            if (dec == DEC_ACCEPT)
                acc_tot++;
            else if (dec == DEC_REVIEW)
                rev_tot++;
            else if (dec == DEC_REJECT)
                rej_tot++;
            return;
        end
        has_rep   = 1'b1;
        rep.rec_n = CNT_FIELD_W'(held_n);
        rep.acc_n = CNT_FIELD_W'(acc_tot);
        rep.rev_n = CNT_FIELD_W'(rev_tot);
        rep.rej_n = CNT_FIELD_W'(rej_tot);
        if (held_n != 0)
        begin
            rep.low_lat  = rank_latency(low_pct);
            rep.high_lat = rank_latency(high_pct);
            rep.max_lat  = lat_sorted[held_n-1];
        end
        rep.ovf = dropped;
        held_n  = 0;
        acc_tot = 0;
        rev_tot = 0;
        rej_tot = 0;
        dropped = 1'b0;
    endtask

    // Insert a random gap whenever the current burst runs out
    task automatic pace_sender();
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
    endtask

    // Offer one request and hold it until the block takes it
    task automatic send_request(input logic op, input logic [LAT_FIELD_W-1:0] lat,
                                input logic [DEC_W-1:0] dec,
                                input logic fixed, input report_t fixed_rep);
        bit      got;
        report_t rep;
        report_t exp_rep;
        pace_sender();
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(IN_DATA_W - LAT_FIELD_W - DEC_W){1'b0}}, dec, lat};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        collect_request(op, lat, dec, got, rep);
        if (got)
        begin
            exp_rep         = fixed ? fixed_rep : rep;
            awaited_reports = {awaited_reports, exp_rep};
            sent_reports++;
        end
        sent_items++;
    endtask

    // Drop valid and wait until every report is back and the chain is quiet
    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_percentiles(input logic [PCT_W-1:0] lo, input logic [PCT_W-1:0] hi);
        drain_block();
        cfg_wen   <= 1'b1;
        cfg_index <= REG_LOW_PCT;
        cfg_data  <= lo;
        @(negedge clk);
        cfg_index <= REG_HIGH_PCT;
        cfg_data  <= hi;
        @(negedge clk);
        cfg_wen   <= 1'b0;
        low_pct  = lo;
        high_pct = hi;
    endtask

    // Mix uniform values with clusters near zero and near full scale
    function automatic logic [LAT_FIELD_W-1:0] rand_latency();
        case ($urandom_range(0, 3))
            0:       return LAT_FIELD_W'($urandom_range(0, 15));
            1:       return {20'hFFFFF, 4'($urandom_range(0, 15))};
            default: return LAT_FIELD_W'($urandom);
        endcase
    endfunction

    // One frame: a run of records, sometimes past the store size, then a report
    task automatic send_frame();
        int n;
        n = ($urandom_range(0, 14) == 0) ? $urandom_range(MAX_REC - 16, MAX_REC + 24)
                                         : $urandom_range(0, 40);
        repeat (n)
            send_request(OP_RECORD, rand_latency(), DEC_W'($urandom_range(0, 3)), 1'b0, '0);
        send_request(OP_REPORT, rand_latency(), DEC_W'($urandom_range(0, 3)), 1'b0, '0);
    endtask

    task automatic run_phase(input logic [PCT_W-1:0] lo, input logic [PCT_W-1:0] hi);
        int item_base;
        int report_base;
        write_percentiles(lo, hi);
        item_base   = sent_items;
        report_base = sent_reports;
        while (sent_items - item_base < PHASE_ITEMS || sent_reports - report_base < PHASE_REPORTS)
            send_frame();
    endtask

    task automatic add_row(input logic op, input logic [LAT_FIELD_W-1:0] lat,
                           input logic [DEC_W-1:0] dec, input int reps,
                           input logic fixed, input report_t want);
        stim_row_t row;
        row.op        = op;
        row.lat       = lat;
        row.dec       = dec;
        row.reps      = 16'(reps);
        row.fixed     = fixed;
        row.want      = want;
        directed_rows = {directed_rows, row};
    endtask

    // Stimulus: directed table, then random frames under several settings
    initial
    begin : stimulus
        stim_row_t row;
        held_n  = 0;
        acc_tot = 0;
        rev_tot = 0;
        rej_tot = 0;
        dropped = 1'b0;
        foreach (lat_sorted[i])
            lat_sorted[i] = '0;

        // empty report straight after reset: all fields zero
        add_row(OP_REPORT, 24'h000000, DEC_ACCEPT, 1, 1'b1, mk_report(0, 0, 0, 0, 0, 0, 0, 0));
        // latency extremes, every class, the unused code and a repeated value
        add_row(OP_RECORD, 24'h000000, DEC_ACCEPT, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'hFFFFFF, DEC_REJECT, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h123456, DEC_REVIEW, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h800000, DEC_UNUSED, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h123456, DEC_ACCEPT, 1, 1'b0, '0);
        add_row(OP_REPORT, 24'hFFFFFF, DEC_UNUSED, 1, 1'b0, '0);
        // a lone record: both percentiles and the maximum land on it
        add_row(OP_RECORD, 24'h000001, DEC_REJECT, 1, 1'b0, '0);
        add_row(OP_REPORT, 24'h000000, DEC_ACCEPT, 1, 1'b1, mk_report(1, 0, 0, 1, 1, 1, 1, 0));
        // back-to-back report finds the store empty again
        add_row(OP_REPORT, 24'h000000, DEC_REVIEW, 1, 1'b1, mk_report(0, 0, 0, 0, 0, 0, 0, 0));
        // descending and alternating patterns
        add_row(OP_RECORD, 24'h00F000, DEC_REVIEW, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h000F00, DEC_REJECT, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h0000F0, DEC_ACCEPT, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'hAAAAAA, DEC_UNUSED, 1, 1'b0, '0);
        add_row(OP_RECORD, 24'h555555, DEC_REVIEW, 1, 1'b0, '0);
        add_row(OP_REPORT, 24'h555555, DEC_REJECT, 1, 1'b0, '0);
        // overfill the store: the extra records are dropped and flagged
        add_row(OP_RECORD, 24'h00ABCD, DEC_ACCEPT, MAX_REC + 4, 1'b0, '0);
        add_row(OP_REPORT, 24'h000000, DEC_ACCEPT, 1, 1'b1,
                mk_report(MAX_REC, MAX_REC, 0, 0, 24'h00ABCD, 24'h00ABCD, 24'h00ABCD, 1));
        // the drop flag is gone after the report
        add_row(OP_RECORD, 24'h000005, DEC_REVIEW, 1, 1'b0, '0);
        add_row(OP_REPORT, 24'h000000, DEC_ACCEPT, 1, 1'b1, mk_report(1, 0, 1, 0, 5, 5, 5, 0));

        @(posedge rst_n);
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            repeat (row.reps)
                send_request(row.op, row.lat, row.dec, row.fixed, row.want);
        end

        // percentile zero picks the minimum, above one hundred the maximum
        run_phase(LOW_PCT_RESET, HIGH_PCT_RESET);
        run_phase(7'd0, 7'd127);
        run_phase(7'd1, 7'd100);
        run_phase(7'd100, 7'd1);
        run_phase(PCT_W'($urandom_range(1, 99)), PCT_W'($urandom_range(1, 99)));
        run_phase(7'd127, 7'd0);

        drain_block();
        if (mismatches == 0)
            $display("latency_percentile_stats_top_tb: done, clean");
        else
            $display("latency_percentile_stats_top_tb: done, errors");
        $finish;
    end

    // Receiver: stall pattern by segments, plus one long hold-off
    initial
    begin : receiver
        int  seg;
        int  mode;
        bit  held_off;
        held_off = 1'b0;
        forever
        begin
            seg  = $urandom_range(5, 60);
            mode = $urandom_range(0, 3);
            repeat (seg)
            begin
                @(negedge clk);
                if (!held_off && results_seen >= 12)
                begin
                    // hold the output long enough for a second report to back up
                    held_off = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (mode)
                    1:       m_tready <= ($urandom_range(0, 1) == 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= 1'b1;
                endcase
            end
        end
    end

    function automatic logic [LAT_FIELD_W-1:0] report_field(input report_t rep, input int k);
        case (k)
            0:       return LAT_FIELD_W'(rep.rec_n);
            1:       return LAT_FIELD_W'(rep.acc_n);
            2:       return LAT_FIELD_W'(rep.rev_n);
            3:       return LAT_FIELD_W'(rep.rej_n);
            4:       return rep.low_lat;
            5:       return rep.high_lat;
            6:       return rep.max_lat;
            default: return LAT_FIELD_W'(rep.ovf);
        endcase
    endfunction

    function automatic string report_field_name(input int k);
        case (k)
            0:       return "record_count";
            1:       return "accept_count";
            2:       return "review_count";
            3:       return "reject_count";
            4:       return "low_pct_latency";
            5:       return "high_pct_latency";
            6:       return "max_latency";
            default: return "overflowed";
        endcase
    endfunction

    // Compare each delivered result with the oldest pending report
    initial
    begin : result_check
        report_t got;
        report_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                results_seen++;
                got.rec_n    = m_tdata[OUT_RC_LSB +: CNT_FIELD_W];
                got.acc_n    = m_tdata[OUT_AC_LSB +: CNT_FIELD_W];
                got.rev_n    = m_tdata[OUT_RV_LSB +: CNT_FIELD_W];
                got.rej_n    = m_tdata[OUT_RJ_LSB +: CNT_FIELD_W];
                got.low_lat  = m_tdata[OUT_LOW_LSB +: LAT_FIELD_W];
                got.high_lat = m_tdata[OUT_HIGH_LSB +: LAT_FIELD_W];
                got.max_lat  = m_tdata[OUT_MAX_LSB +: LAT_FIELD_W];
                got.ovf      = m_tdata[OUT_OVF_BIT];
                if (awaited_reports.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result with no report pending, expected none, got tdata %h",
                             $time, m_tdata);
                end
                else
                begin
                    want = awaited_reports.pop_front();
                    for (int k = 0; k < 8; k++)
                    begin
                        if (report_field(got, k) !== report_field(want, k))
                        begin
                            mismatches++;
                            $display("%0t: %s expected %0d got %0d", $time,
                                     report_field_name(k), report_field(want, k),
                                     report_field(got, k));
                        end
                    end
                end
            end
        end
    end

endmodule

// ----- sim.f -----
sv/lps_pkg.sv
sv/lps_cell.sv
sv/lps_chain.sv
sv/latency_percentile_stats_top.sv
test/latency_percentile_stats_top_tb.sv
